// ----- rtl/two_bit_block_state_map_defines.svh -----
// assertion macros for the two-bit block state map
// used by the top level only; expects clk and rst_n in the calling scope
`ifndef TWO_BIT_BLOCK_STATE_MAP_DEFINES_SVH
`define TWO_BIT_BLOCK_STATE_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define TBBSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbbsm assertion failed");
`define TBBSM_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tbbsm forbidden condition");
`else
`define TBBSM_ASSERT(lbl, prop)
`define TBBSM_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/tbbsm_pkg.sv -----
// shared constants, codes and controller/datapath structs
// for the two-bit block state map; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tbbsm_pkg;

    localparam int MAX_BYTES       = 1024;
    localparam int WORD_W          = 32;
    localparam int BLOCKS_PER_WORD = WORD_W / 2;
    localparam int WORDS           = MAX_BYTES * 8 / WORD_W;
    localparam int WADDR_W         = $clog2(WORDS);
    localparam int LANE_W          = $clog2(BLOCKS_PER_WORD);
    localparam int IDX_W           = 12;
    localparam int REG_W           = 11;
    localparam int CNT_W           = 13;
    localparam int ST_W            = 2;
    localparam int ACT_W           = 2;

    localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COUNT = 2'd2;

    localparam logic [REG_W-1:0] REGION_RESET = REG_W'(MAX_BYTES);

    typedef struct packed {
        logic load;
        logic clear;
        logic set_rd;
        logic set_wr;
        logic scan;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic set_err;
        logic more;
        logic pending;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/two_bit_block_state_map.sv -----
// two-bit block state map: set, find and count over a 1024-byte bitmap held as 32-bit words
// set reads the word and then writes it back with the new state, skipping the write when out of range;
// find and count read one word (16 blocks) a cycle, and find stops at its first hit
// one item at a time; a finished result waits in the output register while the next item is taken
// after reset a clearing pass writes zero to all 256 ram words before any item
// depends on tbbsm_pkg, tbbsm_ctrl, tbbsm_dp and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "two_bit_block_state_map_defines.svh"
module two_bit_block_state_map
    import tbbsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [ACT_W-1:0] action,
    input  wire logic [IDX_W-1:0] block_index,
    input  wire logic [ST_W-1:0]  block_state,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  found,
    output logic      [CNT_W-1:0] result_value,
    output logic                  range_error,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [REG_W-1:0] region_bytes
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tbbsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    tbbsm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .block_index  (block_index),
        .block_state  (block_state),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (region_bytes),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .found        (found),
        .result_value (result_value),
        .range_error  (range_error)
    );

    // an accepted item keeps the input closed for at least the next cycle
    `TBBSM_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready)
    // a range error never comes with a success flag or a value
    `TBBSM_ASSERT_NEVER(a_err_clean, out_valid && range_error && (found || result_value != '0))
    // the ram is never written while an item is being taken
    `TBBSM_ASSERT_NEVER(a_no_wr_idle, in_ready && (cmd.set_wr || cmd.clear))

endmodule
`default_nettype wire

// ----- rtl/tbbsm_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tbbsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tbbsm_ctrl.sv -----
// sequencing state machine for the two-bit block state map
// depends on tbbsm_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbbsm_ctrl
    import tbbsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [ACT_W-1:0] action,
    input  wire dp_status_t       status,
    output dp_cmd_t               cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SET_RD = 6'b000100,
        S_SET_WR = 6'b001000,
        S_SCAN   = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (action) inside
                        ACT_SET:               state_next = S_SET_RD;
                        ACT_FIND, ACT_COUNT:   state_next = S_SCAN;
                        default:               state_next = S_RESP;
                    endcase
                end
            end
            S_SET_RD:
            begin
                cmd.set_rd = 1'b1;
                state_next = status.set_err ? S_RESP : S_SET_WR;
            end
            S_SET_WR:
            begin
                cmd.set_wr = 1'b1;
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || (!status.pending && !status.more))
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tbbsm_dp.sv -----
// datapath: bitmap ram, region register, word scanner and result register
// depends on tbbsm_pkg and tbbsm_ram
`timescale 1ns / 1ps
`default_nettype none
module tbbsm_dp
    import tbbsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_cmd_t          cmd,
    output dp_status_t            status,
    input  wire logic [ACT_W-1:0] action,
    input  wire logic [IDX_W-1:0] block_index,
    input  wire logic [ST_W-1:0]  block_state,
    input  wire logic             cfg_we,
    input  wire logic [REG_W-1:0] cfg_data,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic                  found,
    output logic      [CNT_W-1:0] result_value,
    output logic                  range_error
);

    logic [REG_W-1:0]   region_reg;
    logic [WADDR_W-1:0] clear_cnt_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ST_W-1:0]    st_reg;
    logic [WADDR_W:0]   issue_addr_reg;
    logic               pending_reg;
    logic [WADDR_W-1:0] data_word_reg;
    logic               res_found_reg;
    logic [CNT_W-1:0]   res_value_reg;
    logic               res_err_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [CNT_W-1:0]   out_value_reg;
    logic               out_err_reg;

    logic [REG_W-1:0]          nbytes;
    logic [CNT_W-1:0]          nblocks;
    logic [CNT_W-1:0]          nblocks_m1;
    logic [WADDR_W-1:0]        last_word;
    logic                      more;
    logic                      scan_rd;
    logic                      ram_we;
    logic [WADDR_W-1:0]        ram_waddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [WADDR_W-1:0]        ram_raddr;
    logic [WORD_W-1:0]         rdata;
    logic [WORD_W-1:0]         merged;
    logic [BLOCKS_PER_WORD-1:0] mask;
    logic [LANE_W-1:0]         first_lane;
    logic [LANE_W:0]           pop;
    logic                      process;
    logic                      is_find;

    // bytes in use, clamped to the bitmap size
    assign nbytes     = (region_reg > REG_W'(MAX_BYTES)) ? REG_W'(MAX_BYTES) : region_reg;
    assign nblocks    = {nbytes, 2'b00};
    assign nblocks_m1 = nblocks - CNT_W'(1);
    assign last_word  = nblocks_m1[LANE_W +: WADDR_W];
    assign more       = (nbytes != '0) && (issue_addr_reg <= {1'b0, last_word});
    assign scan_rd    = cmd.scan && more;
    assign is_find    = (act_reg == ACT_FIND);
    assign process    = cmd.scan && pending_reg;

    always_comb
    begin
        merged = rdata;
        merged[{idx_reg[LANE_W-1:0], 1'b0} +: ST_W] = st_reg;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:LANE_W];
        ram_wdata = merged;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.set_wr)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = cmd.set_rd || scan_rd;
    assign ram_raddr = cmd.set_rd ? idx_reg[IDX_W-1:LANE_W] : issue_addr_reg[WADDR_W-1:0];

    tbbsm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // per-block match within the region, and at or after the goal for find
    always_comb
    begin
        logic [IDX_W-1:0] blk;
        for (int k = 0; k < BLOCKS_PER_WORD; k++)
        begin
            blk     = {data_word_reg, LANE_W'(k)};
            mask[k] = (rdata[2*k +: ST_W] == st_reg)
                      && ({1'b0, blk} < nblocks)
                      && (!is_find || (blk >= idx_reg));
        end
    end

    always_comb
    begin
        first_lane = '0;
        for (int k = BLOCKS_PER_WORD - 1; k >= 0; k--)
        begin
            if (mask[k])
            begin
                first_lane = LANE_W'(k);
            end
        end
    end

    assign pop = (LANE_W + 1)'($countones(mask));

    assign status.clear_last = (clear_cnt_reg == WADDR_W'(WORDS - 1));
    assign status.set_err    = ({1'b0, idx_reg[IDX_W-1:2]} >= nbytes);
    assign status.more       = more;
    assign status.pending    = pending_reg;
    assign status.hit        = process && is_find && (mask != '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg    <= REGION_RESET;
            clear_cnt_reg <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                region_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clear_cnt_reg <= clear_cnt_reg + WADDR_W'(1);
            end
            pending_reg <= scan_rd;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg        <= action;
            idx_reg        <= block_index;
            st_reg         <= block_state;
            // find starts at the goal word, count at word zero
            issue_addr_reg <= (action == ACT_FIND) ?
                              {1'b0, block_index[IDX_W-1:LANE_W]} : '0;
            res_found_reg  <= (action == ACT_COUNT);
            res_value_reg  <= '0;
            res_err_reg    <= 1'b0;
        end
        else
        begin
            if (scan_rd)
            begin
                issue_addr_reg <= issue_addr_reg + (WADDR_W + 1)'(1);
            end
            if (cmd.set_rd && status.set_err)
            begin
                res_err_reg <= 1'b1;
            end
            if (cmd.set_wr)
            begin
                res_found_reg <= 1'b1;
            end
            if (process)
            begin
                if (is_find)
                begin
                    if (mask != '0)
                    begin
                        res_found_reg <= 1'b1;
                        res_value_reg <= {1'b0, data_word_reg, first_lane};
                    end
                end
                else
                begin
                    res_value_reg <= res_value_reg + CNT_W'(pop);
                end
            end
        end
        data_word_reg <= issue_addr_reg[WADDR_W-1:0];
        if (cmd.emit)
        begin
            out_found_reg <= res_found_reg;
            out_value_reg <= res_value_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign result_value = out_value_reg;
    assign range_error  = out_err_reg;

endmodule
`default_nettype wire

// ----- verif/state_map_checker.sv -----
// result checker for the two-bit block state map: keeps its own copy of the bitmap
// and region size, predicts each item's result and compares it; needs tbbsm_pkg
`timescale 1ns / 1ps
module state_map_checker
    import tbbsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [ACT_W-1:0] action,
    input  logic [IDX_W-1:0] block_index,
    input  logic [ST_W-1:0]  block_state,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             found,
    input  logic [CNT_W-1:0] result_value,
    input  logic             range_error,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [REG_W-1:0] region_bytes,
    output int               mismatches,
    output int               waiting,
    output int               checked
);

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] value;
        logic             bad_index;
    } lookup_t;

    logic [7:0]       block_map [MAX_BYTES];
    logic [REG_W-1:0] region;
    lookup_t          pending_lookups [$];

    function automatic int unsigned blocks_in_use();
        int unsigned nbytes;
        nbytes = (int'(region) > MAX_BYTES) ? MAX_BYTES : int'(region);
        return nbytes * 4;
    endfunction

    function automatic logic [ST_W-1:0] state_at(input int unsigned blk);
        return block_map[blk / 4][(blk % 4) * 2 +: 2];
    endfunction

    // applies one item to the local bitmap and returns the result it should give
    function automatic lookup_t map_outcome(input logic [ACT_W-1:0] act,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [ST_W-1:0]  st);
        lookup_t     r;
        int unsigned limit;
        int unsigned b;
        r = '0;
        limit = blocks_in_use();
        case (act)
            ACT_SET:
            begin
                if (idx >= limit)
                    r.bad_index = 1'b1;
                else
                begin
                    block_map[idx / 4][(idx % 4) * 2 +: 2] = st;
                    r.hit = 1'b1;
                end
            end
            ACT_FIND:
            begin
                for (b = idx; b < limit; b++)
                begin
                    if (state_at(b) == st)
                    begin
                        r.hit   = 1'b1;
                        r.value = CNT_W'(b);
                        break;
                    end
                end
            end
            ACT_COUNT:
            begin
                r.hit = 1'b1;
                for (b = 0; b < limit; b++)
                    if (state_at(b) == st)
                        r.value = r.value + 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lookup_t want;
        if (!rst_n)
        begin
            foreach (block_map[i])
                block_map[i] = '0;
            region = REGION_RESET;
            pending_lookups.delete();
            mismatches = 0;
            checked    = 0;
            waiting   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $error("result with no item outstanding: found %0d value %0d range_error %0d",
                           found, result_value, range_error);
                    mismatches++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    checked++;
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0d, got %0d", want.hit, found);
                        mismatches++;
                    end
                    if (result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d", want.value, result_value);
                        mismatches++;
                    end
                    if (range_error !== want.bad_index)
                    begin
                        $error("range_error: expected %0d, got %0d", want.bad_index, range_error);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                region = region_bytes;
            if (in_valid && in_ready)
                pending_lookups.push_back(map_outcome(action, block_index, block_state));
            waiting <= pending_lookups.size();
        end
    end

endmodule

// ----- verif/two_bit_block_state_map_tb.sv -----
// testbench top for the two-bit block state map: clock, reset, stimulus, watchdog and verdict
// depends on tbbsm_pkg, the block itself and state_map_checker
`timescale 1ns / 1ps
module two_bit_block_state_map_tb
    import tbbsm_pkg::*;
();

    localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
    localparam logic [ST_W-1:0]  ST_FREE     = 2'd0;
    localparam logic [ST_W-1:0]  ST_USED     = 2'd1;
    localparam logic [ST_W-1:0]  ST_FREEMETA = 2'd2;
    localparam logic [ST_W-1:0]  ST_USEDMETA = 2'd3;
    localparam int               QUIET_LIMIT = 6000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] block_index;
    logic [ST_W-1:0]  block_state;
    logic             out_valid;
    logic             out_ready;
    logic             found;
    logic [CNT_W-1:0] result_value;
    logic             range_error;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [REG_W-1:0] region_bytes;

    int mismatches;
    int waiting;
    int checked;
    int quiet_cycles;

    bit          steady;
    int unsigned region_now;
    int          n_set, n_find, n_count, n_other, n_cfg;

    two_bit_block_state_map u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_index  (block_index),
        .block_state  (block_state),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_value (result_value),
        .range_error  (range_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .region_bytes (region_bytes)
    );

    state_map_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_index  (block_index),
        .block_state  (block_state),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_value (result_value),
        .range_error  (range_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .region_bytes (region_bytes),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one, none at all in steady phases
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned blocks_now();
        return ((region_now > MAX_BYTES) ? MAX_BYTES : region_now) * 4;
    endfunction

    // mostly inside the region, sometimes anywhere
    function automatic int unsigned pick_block();
        if (blocks_now() == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, blocks_now() - 1);
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input int unsigned idx,
                             input logic [ST_W-1:0] st);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        block_index <= idx[IDX_W-1:0];
        block_state <= st;
        do @(posedge clk); while (!in_ready);
        case (act)
            ACT_SET:   n_set++;
            ACT_FIND:  n_find++;
            ACT_COUNT: n_count++;
            default:   n_other++;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_region(input int unsigned val);
        drain();
        cfg_valid    <= 1'b1;
        region_bytes <= val[REG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        region_now  = val & 11'h7FF;
        n_cfg++;
    endtask

    task automatic run_phase(input int n);
        int          i;
        int unsigned r;
        int unsigned start;
        int unsigned len;
        logic [ST_W-1:0] fill;
        i = 0;
        while (i < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                // a run of equal states, then a search across it
                start = pick_block();
                len   = $urandom_range(8, 48);
                fill  = ST_W'($urandom_range(0, 3));
                for (int k = 0; k < len; k++)
                    send_item(ACT_SET, (start + k) % 4096, fill);
                send_item(ACT_FIND, start, ST_W'($urandom_range(0, 3)));
                i += len + 1;
            end
            else
            begin
                if (r < 55)
                    send_item(ACT_SET, pick_block(), ST_W'($urandom_range(0, 3)));
                else if (r < 82)
                    send_item(ACT_FIND, pick_block(), ST_W'($urandom_range(0, 3)));
                else if (r < 96)
                    send_item(ACT_COUNT, pick_block(), ST_W'($urandom_range(0, 3)));
                else
                    send_item(ACT_UNUSED, pick_block(), ST_W'($urandom_range(0, 3)));
                i++;
            end
        end
    endtask

    initial
    begin : out_side
        int unsigned hold;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // counts cycles without any handshake on the three channels
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("** two_bit_block_state_map: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned sizes [12];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_SET;
        block_index  = '0;
        block_state  = ST_FREE;
        cfg_valid    = 1'b0;
        region_bytes = REGION_RESET;
        quiet_cycles = 0;
        steady       = 1'b0;
        region_now   = MAX_BYTES;
        n_set = 0; n_find = 0; n_count = 0; n_other = 0; n_cfg = 0;
        sizes = '{4, 1, 2047, 64, 0, 1025, 300, 1024, 2, 1, 17, 1023};
        sizes[9] = $urandom_range(1, 1024);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // region at its reset size, every block free
        send_item(ACT_COUNT, 0, ST_FREE);
        send_item(ACT_FIND, 0, ST_USED);
        send_item(ACT_SET, 0, ST_USEDMETA);
        send_item(ACT_SET, 4095, ST_USED);
        send_item(ACT_SET, 4094, ST_FREEMETA);
        send_item(ACT_SET, 2048, ST_USED);
        send_item(ACT_FIND, 0, ST_USEDMETA);
        send_item(ACT_FIND, 1, ST_USED);
        send_item(ACT_FIND, 2049, ST_USED);
        send_item(ACT_FIND, 0, ST_FREEMETA);
        send_item(ACT_FIND, 0, ST_FREE);
        send_item(ACT_COUNT, 4095, ST_USED);
        send_item(ACT_UNUSED, 4095, ST_USEDMETA);
        send_item(ACT_FIND, 4094, ST_FREE);

        // two bytes in use: set past the end, search past the end
        write_region(2);
        send_item(ACT_SET, 8, ST_USED);
        send_item(ACT_SET, 7, ST_USEDMETA);
        send_item(ACT_FIND, 1, ST_USEDMETA);
        send_item(ACT_FIND, 0, ST_USED);
        send_item(ACT_COUNT, 0, ST_FREE);
        send_item(ACT_FIND, 8, ST_FREE);

        // empty region
        write_region(0);
        send_item(ACT_SET, 0, ST_FREE);
        send_item(ACT_FIND, 0, ST_FREE);
        send_item(ACT_COUNT, 0, ST_FREE);

        // oversized region clips to the full map
        write_region(2047);
        send_item(ACT_SET, 4095, ST_FREE);
        send_item(ACT_COUNT, 0, ST_USED);

        for (int p = 0; p < 12; p++)
        begin
            steady = (p == 3 || p == 8);
            write_region(sizes[p]);
            run_phase((sizes[p] == 0) ? 40 : 100);
        end
        steady = 1'b0;

        drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d items: %0d set, %0d find, %0d count, %0d unused action",
                 n_set + n_find + n_count + n_other, n_set, n_find, n_count, n_other);
        $display("%0d results checked over %0d region writes, empty and oversized included",
                 checked, n_cfg);
        if (mismatches == 0 && waiting == 0)
            $display("** two_bit_block_state_map: PASSED **");
        else
            $display("** two_bit_block_state_map: FAILED **");
        $finish;
    end

endmodule
